// ===== design/dhe_pkg.sv =====
// Shared constants and types for the DHCP host name extractor.
`timescale 1ns / 1ps
`default_nettype none
package dhe_pkg;

  localparam int MinLen     = 43;
  localparam int MacFirst   = 28;
  localparam int MacLast    = 33;
  localparam int HdrLast    = 239;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_HOSTNAME = 8'd12;
  localparam logic [7:0] OPT_END      = 8'd255;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SHORT   = 2'd1;
  localparam logic [1:0] STATUS_NO_NAME = 2'd2;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_CODE    = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_NAMELEN = 3'd4;
  localparam logic [2:0] PH_NAME    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  typedef struct packed {
    logic take;
    logic fetch;
    logic load;
    logic adv;
    logic clear;
  } dhe_cmd_t;

endpackage
`default_nettype wire

// ===== design/dhe_ctrl.sv =====
// Controller: receive, fetch, load and result hand-off sequencing.
`timescale 1ns / 1ps
`default_nettype none
module dhe_ctrl
  import dhe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     last_byte_i,
  input  wire logic     out_ready_i,
  input  wire logic     out_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output dhe_cmd_t      cmd_o
);

  localparam logic [1:0] S_RX    = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_SHOW  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_acc, out_acc;

  assign in_ready_o  = (state_q == S_RX);
  assign out_valid_o = (state_q == S_SHOW);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.take  = in_acc;
    case (state_q)
      S_RX: begin
        if (in_acc && last_byte_i) state_d = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_SHOW;
      end
      S_SHOW: begin
        if (out_acc) begin
          if (out_last_i) begin
            cmd_o.clear = 1'b1;
            state_d     = S_RX;
          end else begin
            cmd_o.adv = 1'b1;
          end
        end
      end
      default: state_d = S_RX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RX;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/dhe_dp.sv =====
// Datapath: option walker, name memory and result registers.
`timescale 1ns / 1ps
`default_nettype none
module dhe_dp
  import dhe_pkg::*;
#(
  parameter int MAX_PACKET = 16384,
  parameter int NAME_DEPTH = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dhe_cmd_t    cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_last_o,
  output logic [47:0]      client_mac_o,
  output logic [1:0]       status_o,
  output logic [5:0]       name_length_o,
  output logic [7:0]       name_byte_o,
  output logic [5:0]       name_index_o
);

  localparam int OW  = $clog2(MAX_PACKET + 1);
  localparam int NAW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

  logic [OW-1:0] off_q, off_d;
  logic [47:0]   mac_q, mac_d;
  logic [2:0]    phase_q, phase_d;
  logic [7:0]    skip_q, skip_d;
  logic [5:0]    count_q, count_d;
  logic [7:0]    left_q, left_d;
  logic          closed_q, closed_d;
  logic          wr_en;
  logic [7:0]    skip_dec, left_dec;

  logic [7:0]    mem [NAME_DEPTH];
  logic [7:0]    rd_data_q;
  logic [6:0]    rd_addr;

  logic [1:0]    status;
  logic [5:0]    idx_q;
  logic          last_q;

  assign skip_dec = (skip_q != 8'd0) ? skip_q - 8'd1 : 8'd0;
  assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;

  always_comb begin
    off_d    = off_q;
    mac_d    = mac_q;
    phase_d  = phase_q;
    skip_d   = skip_q;
    count_d  = count_q;
    left_d   = left_q;
    closed_d = closed_q;
    wr_en    = 1'b0;
    if (cmd_i.clear) begin
      off_d    = '0;
      mac_d    = '0;
      phase_d  = PH_HEADER;
      skip_d   = '0;
      count_d  = '0;
      left_d   = '0;
      closed_d = 1'b0;
    end else if (cmd_i.take && (off_q < OW'(MAX_PACKET))) begin
      off_d = off_q + OW'(1);
      if ((off_q >= OW'(MacFirst)) && (off_q <= OW'(MacLast))) begin
        mac_d = {mac_q[39:0], data_byte_i};
      end
      case (phase_q)
        PH_HEADER: begin
          if (off_q == OW'(HdrLast)) phase_d = PH_CODE;
        end
        PH_CODE: begin
          if (data_byte_i == OPT_PAD) begin
            phase_d = PH_CODE;
          end else if (data_byte_i == OPT_END) begin
            phase_d = PH_DONE;
          end else if (data_byte_i == OPT_HOSTNAME) begin
            phase_d = PH_NAMELEN;
          end else begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          skip_d  = data_byte_i;
          phase_d = (data_byte_i != 8'd0) ? PH_SKIP : PH_CODE;
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 8'd0) phase_d = PH_CODE;
        end
        PH_NAMELEN: begin
          left_d  = data_byte_i;
          phase_d = (data_byte_i != 8'd0) ? PH_NAME : PH_DONE;
        end
        PH_NAME: begin
          if (!closed_q) begin
            if (data_byte_i == 8'd0) begin
              closed_d = 1'b1;
            end else if (count_q < 6'(NAME_DEPTH)) begin
              wr_en   = 1'b1;
              count_d = count_q + 6'd1;
            end
          end
          left_d = left_dec;
          if (left_dec == 8'd0) phase_d = PH_DONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      mac_q    <= '0;
      phase_q  <= PH_HEADER;
      skip_q   <= '0;
      count_q  <= '0;
      left_q   <= '0;
      closed_q <= 1'b0;
    end else begin
      off_q    <= off_d;
      mac_q    <= mac_d;
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      count_q  <= count_d;
      left_q   <= left_d;
      closed_q <= closed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[count_q[NAW-1:0]] <= data_byte_i;
  end

  always_comb begin
    if (cmd_i.fetch) begin
      rd_addr = 7'd0;
    end else if (cmd_i.load) begin
      rd_addr = 7'd1;
    end else if (cmd_i.adv) begin
      rd_addr = {1'b0, idx_q} + 7'd2;
    end else begin
      rd_addr = {1'b0, idx_q} + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_addr < 7'(NAME_DEPTH)) rd_data_q <= mem[rd_addr[NAW-1:0]];
  end

  always_comb begin
    if (off_q < OW'(MinLen)) begin
      status = STATUS_SHORT;
    end else if (count_q == 6'd0) begin
      status = STATUS_NO_NAME;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      client_mac_o  <= (status == STATUS_SHORT) ? 48'd0 : mac_q;
      status_o      <= status;
      name_length_o <= (status == STATUS_OK) ? count_q : 6'd0;
      name_byte_o   <= (status == STATUS_OK) ? rd_data_q : 8'd0;
      idx_q         <= 6'd0;
      last_q        <= (status != STATUS_OK) || (count_q == 6'd1);
    end else if (cmd_i.adv) begin
      name_byte_o <= rd_data_q;
      idx_q       <= idx_q + 6'd1;
      last_q      <= ({1'b0, idx_q} + 7'd2) == {1'b0, count_q};
    end
  end

  assign name_index_o = idx_q;
  assign out_last_o   = last_q;

endmodule
`default_nettype wire

// ===== design/dhcp_hostname_extractor_core.sv =====
// Top level of the DHCP host name extractor.
// Payload bytes are taken one item per cycle for the whole packet; the option walker
// parses each byte as it arrives. After the item marked last the block stops taking
// input while the name memory read is primed, then hands out one result per cycle
// while out_ready_i is high (one per kept name byte, or a single status result),
// paced by the single read port of the name memory. Input resumes in the cycle
// after the final result is taken. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module dhcp_hostname_extractor_core
  import dhe_pkg::*;
#(
  parameter int MAX_PACKET = 16384,
  parameter int NAME_DEPTH = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [47:0]      client_mac_o,
  output logic [1:0]       status_o,
  output logic [5:0]       name_length_o,
  output logic [7:0]       name_byte_o,
  output logic [5:0]       name_index_o,
  output logic             last_result_o
);

  dhe_cmd_t cmd;
  logic     out_last;

  dhe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .out_ready_i (out_ready_i),
    .out_last_i  (out_last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  dhe_dp #(
    .MAX_PACKET (MAX_PACKET),
    .NAME_DEPTH (NAME_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .out_last_o    (out_last),
    .client_mac_o  (client_mac_o),
    .status_o      (status_o),
    .name_length_o (name_length_o),
    .name_byte_o   (name_byte_o),
    .name_index_o  (name_index_o)
  );

  assign last_result_o = out_last;

endmodule
`default_nettype wire

// ===== design/dhe_checker.sv =====
// Port-level checker for the DHCP host name extractor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dhe_checker
  import dhe_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  data_byte_i,
  input wire logic        last_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [47:0] client_mac_o,
  input wire logic [1:0]  status_o,
  input wire logic [5:0]  name_length_o,
  input wire logic [7:0]  name_byte_o,
  input wire logic [5:0]  name_index_o,
  input wire logic        last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(name_byte_o)
      && $stable(name_index_o) && $stable(status_o) && $stable(last_result_o)))
    else $error("result item changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while results are pending");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |->
      (last_result_o && name_index_o == 6'd0 && name_length_o == 6'd0))
    else $error("status result is not a single final item");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_OK) |-> (name_index_o < name_length_o))
    else $error("name index beyond name length");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_result_o) |=>
      (out_valid_o && name_index_o == 6'($past(name_index_o) + 6'd1)))
    else $error("name bytes not given in order");

endmodule

bind dhcp_hostname_extractor_core dhe_checker u_dhe_checker (.*);
`default_nettype wire
